@@ rtl/box_collision_impulse_resolver_defines.svh @@
// assertion macros for the box collision impulse resolver checker
// no dependencies; included by the checker file only
`ifndef BOX_COLLISION_IMPULSE_RESOLVER_DEFINES_SVH
`define BOX_COLLISION_IMPULSE_RESOLVER_DEFINES_SVH

// check with reset masking
`define BCIR_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("bcir port check failed");

// check that also runs while reset is applied
`define BCIR_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) else $error("bcir reset check failed");

`endif

@@ rtl/bcir_pkg.sv @@
// shared constants and types of the box collision impulse resolver
// no dependencies; used by the top level by scoped names
package bcir_pkg;

    localparam int MAX_SPR   = 16;
    localparam int IDX_W     = $clog2(MAX_SPR);
    localparam int CNT_W     = $clog2(MAX_SPR + 1);
    localparam int MAX_PAIRS = MAX_SPR * (MAX_SPR - 1) / 2;
    localparam int PAIR_W    = $clog2(MAX_PAIRS + 1);
    localparam int FRAC_BITS = 16;

    localparam logic [9:0]  SPM_RESET = 10'd1;
    localparam logic        REG_SPM   = 1'b0;
    localparam logic [15:0] NORM_MAX  = 16'd32767;

    // shared divider: remainder, dividend stream and quotient widths
    localparam int REM_W      = 31;
    localparam int DIV_W      = 39;
    localparam int CNT_DIV_W  = 6;
    localparam logic [CNT_DIV_W-1:0] NORM_STEPS = 6'd16;
    localparam logic [CNT_DIV_W-1:0] IMP_STEPS  = 6'd39;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic [15:0]        box_w;
        logic [15:0]        box_h;
        logic [15:0]        bounce;
        logic [23:0]        inv_mass;
    } t_sprite;

    typedef struct packed {
        logic signed [31:0] vy;
        logic signed [31:0] vx;
    } t_vel;

    typedef struct packed {
        logic [IDX_W-1:0]   a;
        logic [IDX_W-1:0]   b;
        logic signed [15:0] nx;
        logic signed [15:0] ny;
    } t_contact;

    typedef enum logic [24:0] {
        S_IDLE  = 25'd1,
        S_DRD   = 25'd1 << 1,
        S_DMUL  = 25'd1 << 2,
        S_DCMP  = 25'd1 << 3,
        S_DSQ   = 25'd1 << 4,
        S_DSUM  = 25'd1 << 5,
        S_DROOT = 25'd1 << 6,
        S_DDVLD = 25'd1 << 7,
        S_DDIV  = 25'd1 << 8,
        S_DWR   = 25'd1 << 9,
        S_DNEXT = 25'd1 << 10,
        S_RRD   = 25'd1 << 11,
        S_RVRD  = 25'd1 << 12,
        S_RMUL  = 25'd1 << 13,
        S_RDOT  = 25'd1 << 14,
        S_RSE   = 25'd1 << 15,
        S_RDV   = 25'd1 << 16,
        S_RDVLD = 25'd1 << 17,
        S_RDIV  = 25'd1 << 18,
        S_RUMUL = 25'd1 << 19,
        S_RWA   = 25'd1 << 20,
        S_RWB   = 25'd1 << 21,
        S_RNEXT = 25'd1 << 22,
        S_ORD   = 25'd1 << 23,
        S_OEMIT = 25'd1 << 24
    } t_state;

endpackage

@@ rtl/box_collision_impulse_resolver.sv @@
// box collision impulse resolver: sprite store, pair test, contact list, impulse solve
// depends on bcir_pkg
//
// Usage: sprites are loaded one word per start pulse while busy is low. Each
// loaded word is written to the sprite and velocity memories.
// The word with i_last_sprite set closes the set; busy then rises and stays
// high until the last result has gone out. Up to 16 sprites are kept, later
// words are dropped (a dropped last word still closes the set).
// Work after the closing word: every pair is tested, and a touching pair then runs a
// 31-step square root and a 16-step divider (both skipped when the centres coincide);
// then every stored contact runs the 39-step impulse divider unless it is skipped,
// and then the results go out.
// Results: one per sprite in load order, each shown for one cycle with
// o_valid, the last one with o_last_result; the receiver cannot stall.
// spaces_per_metre is written through the APB port at address 0, by the user only while
// idle; the block does not enforce this. Reset (synchronous, active low) empties the set
// and returns to idle; memory contents are not cleared.
module box_collision_impulse_resolver (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               start,
    output logic               busy,
    input  logic               i_last_sprite,
    input  logic signed [31:0] i_pos_x,
    input  logic signed [31:0] i_pos_y,
    input  logic signed [31:0] i_vel_x,
    input  logic signed [31:0] i_vel_y,
    input  logic [15:0]        i_box_width,
    input  logic [15:0]        i_box_height,
    input  logic [15:0]        i_bounce,
    input  logic [23:0]        i_inv_mass,
    output logic               o_valid,
    output logic [5:0]         o_sprite_index,
    output logic signed [31:0] o_new_vel_x,
    output logic signed [31:0] o_new_vel_y,
    output logic [10:0]        o_collision_count,
    output logic               o_last_result
);

    localparam int IW = bcir_pkg::IDX_W;
    localparam int CW = bcir_pkg::CNT_W;
    localparam int PW = bcir_pkg::PAIR_W;
    localparam int FB = bcir_pkg::FRAC_BITS;
    localparam int RW = bcir_pkg::REM_W;
    localparam int DW = bcir_pkg::DIV_W;

    bcir_pkg::t_state   r_state;
    logic [9:0]         r_spm;
    logic [CW-1:0]      r_cnt;
    logic [PW-1:0]      r_ccnt;
    logic [PW-1:0]      r_k;
    logic [CW-1:0]      r_i;
    logic [CW-1:0]      r_j;

    // memories
    bcir_pkg::t_sprite  r_spr_mem [bcir_pkg::MAX_SPR];
    bcir_pkg::t_vel     r_vel_mem [bcir_pkg::MAX_SPR];
    bcir_pkg::t_contact r_con_mem [bcir_pkg::MAX_PAIRS];
    bcir_pkg::t_sprite  r_spa;
    bcir_pkg::t_sprite  r_spb;
    bcir_pkg::t_vel     r_va;
    bcir_pkg::t_vel     r_vb;
    bcir_pkg::t_contact r_cd;

    // pair test datapath
    logic [32:0]        r_ax;
    logic [32:0]        r_ay;
    logic               r_negx;
    logic               r_negy;
    logic [42:0]        r_mx;
    logic [42:0]        r_my;
    logic [16:0]        r_wsum;
    logic [16:0]        r_hsum;
    logic [59:0]        r_sqx;
    logic [59:0]        r_sqy;
    logic [61:0]        r_rem;
    logic [61:0]        r_root;
    logic [61:0]        r_bit;

    // shared two-lane divider
    logic [RW-1:0]      r_dr   [2];
    logic [DW-1:0]      r_dd   [2];
    logic [DW-1:0]      r_dq   [2];
    logic [RW-1:0]      r_dsor;
    logic [bcir_pkg::CNT_DIV_W-1:0] r_dcnt;

    // impulse datapath
    logic signed [48:0] r_px;
    logic signed [48:0] r_py;
    logic [24:0]        r_tot;
    logic [31:0]        r_bp;
    logic [34:0]        r_s;
    logic [16:0]        r_e;
    logic [51:0]        r_se;
    logic [62:0]        r_pa;
    logic [62:0]        r_pb;
    logic signed [55:0] r_uxa;
    logic signed [55:0] r_uya;
    logic signed [55:0] r_uxb;
    logic signed [55:0] r_uyb;

    logic               acc;
    logic               store;
    logic [CW-1:0]      cnt_next;
    logic               cfg_wr;
    logic               spr_we;
    bcir_pkg::t_sprite  spr_wd;
    logic [IW-1:0]      spr_ra;
    logic [IW-1:0]      spr_rb;
    logic               vel_we;
    logic [IW-1:0]      vel_wa;
    bcir_pkg::t_vel     vel_wd;
    logic [IW-1:0]      vel_ra;
    logic               con_we;
    bcir_pkg::t_contact con_wd;
    logic signed [32:0] dx;
    logic signed [32:0] dy;
    logic [32:0]        ax;
    logic [32:0]        ay;
    logic               ovl;
    logic [32:0]        orv;
    logic [1:0]         sh;
    logic [61:0]        trial;
    logic               root_ge;
    logic [RW:0]        dt     [2];
    logic               dge    [2];
    logic [15:0]        qc     [2];
    logic signed [32:0] dvx;
    logic signed [32:0] dvy;
    logic signed [49:0] dot;
    logic [49:0]        negdot;
    logic [38:0]        dv;
    logic [PW-1:0]      k1;
    logic signed [31:0] new_ax;
    logic signed [31:0] new_ay;
    logic signed [31:0] new_bx;
    logic signed [31:0] new_by;

    // divide by 32768, rounding toward zero
    function automatic logic signed [40:0] trunc15(input logic signed [55:0] p);
        logic signed [55:0] adj;
        adj = p[55] ? p + 56'sd32767 : p;
        return adj[55:15];
    endfunction

    function automatic logic signed [31:0] sat_add(input logic signed [31:0] v,
                                                   input logic signed [40:0] d,
                                                   input logic sub);
        logic signed [41:0] sum;
        sum = sub ? {{10{v[31]}}, v} - {d[40], d} : {{10{v[31]}}, v} + {d[40], d};
        if (sum[41:31] == {11{sum[41]}}) begin
            return sum[31:0];
        end else if (sum[41]) begin
            return {1'b1, 31'b0};
        end else begin
            return {1'b0, {31{1'b1}}};
        end
    endfunction

    assign busy    = (r_state != bcir_pkg::S_IDLE);
    assign acc     = start && !busy;
    assign store   = acc && (r_cnt < CW'(bcir_pkg::MAX_SPR));
    assign cnt_next = store ? r_cnt + CW'(1) : r_cnt;

    // configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign prdata = (paddr[2] == bcir_pkg::REG_SPM) ? {22'b0, r_spm} : 32'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_spm <= bcir_pkg::SPM_RESET;
        end else if (cfg_wr && paddr[2] == bcir_pkg::REG_SPM) begin
            r_spm <= pwdata[9:0];
        end
    end

    // memory port selection
    always_comb begin
        spr_we = store;
        spr_wd = '{pos_x: i_pos_x, pos_y: i_pos_y, box_w: i_box_width,
                   box_h: i_box_height, bounce: i_bounce, inv_mass: i_inv_mass};
        if (r_state == bcir_pkg::S_DRD || r_state == bcir_pkg::S_DMUL) begin
            spr_ra = r_i[IW-1:0];
            spr_rb = r_j[IW-1:0];
        end else begin
            spr_ra = r_cd.a;
            spr_rb = r_cd.b;
        end
        if (r_state == bcir_pkg::S_ORD || r_state == bcir_pkg::S_OEMIT) begin
            vel_ra = r_k[IW-1:0];
        end else begin
            vel_ra = r_cd.a;
        end
        vel_we = 1'b0;
        vel_wa = r_cnt[IW-1:0];
        vel_wd = '{vy: i_vel_y, vx: i_vel_x};
        if (store) begin
            vel_we = 1'b1;
        end else if (r_state == bcir_pkg::S_RWA) begin
            vel_we = 1'b1;
            vel_wa = r_cd.a;
            vel_wd = '{vy: new_ay, vx: new_ax};
        end else if (r_state == bcir_pkg::S_RWB) begin
            vel_we = 1'b1;
            vel_wa = r_cd.b;
            vel_wd = '{vy: new_by, vx: new_bx};
        end
        con_we = (r_state == bcir_pkg::S_DWR);
        con_wd.a  = r_i[IW-1:0];
        con_wd.b  = r_j[IW-1:0];
        con_wd.nx = r_negx ? -$signed(qc[0]) : $signed(qc[0]);
        con_wd.ny = r_negy ? -$signed(qc[1]) : $signed(qc[1]);
    end

    always_ff @(posedge i_clk) begin
        if (spr_we) begin
            r_spr_mem[r_cnt[IW-1:0]] <= spr_wd;
        end
        r_spa <= r_spr_mem[spr_ra];
        r_spb <= r_spr_mem[spr_rb];
    end

    always_ff @(posedge i_clk) begin
        if (vel_we) begin
            r_vel_mem[vel_wa] <= vel_wd;
        end
        r_va <= r_vel_mem[vel_ra];
        r_vb <= r_vel_mem[r_cd.b];
    end

    always_ff @(posedge i_clk) begin
        if (con_we) begin
            r_con_mem[r_ccnt] <= con_wd;
        end
        r_cd <= r_con_mem[r_k];
    end

    // combinational datapath pieces
    always_comb begin
        dx  = {r_spa.pos_x[31], r_spa.pos_x} - {r_spb.pos_x[31], r_spb.pos_x};
        dy  = {r_spa.pos_y[31], r_spa.pos_y} - {r_spb.pos_y[31], r_spb.pos_y};
        ax  = dx[32] ? 33'(-dx) : 33'(dx);
        ay  = dy[32] ? 33'(-dy) : 33'(dy);
        ovl = ({r_mx, 1'b0} < 44'({r_wsum, {FB{1'b0}}}))
           && ({r_my, 1'b0} < 44'({r_hsum, {FB{1'b0}}}));
        orv = r_ax | r_ay;
        // bring both offsets below 2^30
        if (orv[32]) begin
            sh = 2'd3;
        end else if (orv[31]) begin
            sh = 2'd2;
        end else if (orv[30]) begin
            sh = 2'd1;
        end else begin
            sh = 2'd0;
        end
        trial   = r_root + r_bit;
        root_ge = (r_rem >= trial);
        for (int l = 0; l < 2; l++) begin
            dt[l]  = {r_dr[l], r_dd[l][DW-1]};
            dge[l] = (dt[l] >= {1'b0, r_dsor});
            qc[l]  = (r_dq[l] > DW'(bcir_pkg::NORM_MAX)) ? bcir_pkg::NORM_MAX
                                                         : r_dq[l][15:0];
        end
        dvx    = {r_va.vx[31], r_va.vx} - {r_vb.vx[31], r_vb.vx};
        dvy    = {r_va.vy[31], r_va.vy} - {r_vb.vy[31], r_vb.vy};
        dot    = {r_px[48], r_px} + {r_py[48], r_py};
        negdot = 50'(-dot);
        dv     = {4'b0, r_s} + {1'b0, r_se[51:14]};
        k1     = r_k + PW'(1);
        new_ax = sat_add(r_va.vx, trunc15(r_uxa), 1'b0);
        new_ay = sat_add(r_va.vy, trunc15(r_uya), 1'b0);
        new_bx = sat_add(r_vb.vx, trunc15(r_uxb), 1'b1);
        new_by = sat_add(r_vb.vy, trunc15(r_uyb), 1'b1);
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bcir_pkg::S_IDLE;
            r_cnt   <= '0;
            r_ccnt  <= '0;
        end else begin
            case (r_state)
                bcir_pkg::S_IDLE: begin
                    if (acc) begin
                        r_cnt <= cnt_next;
                        if (i_last_sprite) begin
                            r_ccnt <= '0;
                            r_k    <= '0;
                            r_i    <= '0;
                            r_j    <= CW'(1);
                            r_state <= (cnt_next < CW'(2)) ? bcir_pkg::S_ORD
                                                           : bcir_pkg::S_DRD;
                        end
                    end
                end
                bcir_pkg::S_DRD: begin
                    r_state <= bcir_pkg::S_DMUL;
                end
                bcir_pkg::S_DMUL: begin
                    r_ax   <= ax;
                    r_ay   <= ay;
                    r_negx <= dx[32];
                    r_negy <= dy[32];
                    r_mx   <= 43'(ax) * 43'(r_spm);
                    r_my   <= 43'(ay) * 43'(r_spm);
                    r_wsum <= 17'(r_spa.box_w) + 17'(r_spb.box_w);
                    r_hsum <= 17'(r_spa.box_h) + 17'(r_spb.box_h);
                    r_state <= bcir_pkg::S_DCMP;
                end
                bcir_pkg::S_DCMP: begin
                    r_ax <= r_ax >> sh;
                    r_ay <= r_ay >> sh;
                    if (!ovl) begin
                        r_state <= bcir_pkg::S_DNEXT;
                    end else if (orv == '0) begin
                        // coincident centres keep a zero normal
                        r_dq[0] <= '0;
                        r_dq[1] <= '0;
                        r_state <= bcir_pkg::S_DWR;
                    end else begin
                        r_state <= bcir_pkg::S_DSQ;
                    end
                end
                bcir_pkg::S_DSQ: begin
                    r_sqx <= 60'(r_ax[29:0]) * 60'(r_ax[29:0]);
                    r_sqy <= 60'(r_ay[29:0]) * 60'(r_ay[29:0]);
                    r_state <= bcir_pkg::S_DSUM;
                end
                bcir_pkg::S_DSUM: begin
                    r_rem  <= 62'(r_sqx) + 62'(r_sqy);
                    r_root <= '0;
                    r_bit  <= 62'(1) << 60;
                    r_state <= bcir_pkg::S_DROOT;
                end
                bcir_pkg::S_DROOT: begin
                    if (root_ge) begin
                        r_rem  <= r_rem - trial;
                        r_root <= (r_root >> 1) + r_bit;
                    end else begin
                        r_root <= r_root >> 1;
                    end
                    r_bit <= r_bit >> 2;
                    if (r_bit[0]) begin
                        r_state <= bcir_pkg::S_DDVLD;
                    end
                end
                bcir_pkg::S_DDVLD: begin
                    r_dr[0] <= RW'(r_ax[29:1]);
                    r_dr[1] <= RW'(r_ay[29:1]);
                    r_dd[0] <= {r_ax[0], {(DW-1){1'b0}}};
                    r_dd[1] <= {r_ay[0], {(DW-1){1'b0}}};
                    r_dq[0] <= '0;
                    r_dq[1] <= '0;
                    r_dsor  <= r_root[RW-1:0];
                    r_dcnt  <= bcir_pkg::NORM_STEPS;
                    r_state <= bcir_pkg::S_DDIV;
                end
                bcir_pkg::S_DDIV, bcir_pkg::S_RDIV: begin
                    for (int l = 0; l < 2; l++) begin
                        r_dr[l] <= dge[l] ? RW'(dt[l] - {1'b0, r_dsor}) : dt[l][RW-1:0];
                        r_dd[l] <= r_dd[l] << 1;
                        r_dq[l] <= {r_dq[l][DW-2:0], dge[l]};
                    end
                    r_dcnt <= r_dcnt - 1'b1;
                    if (r_dcnt == 1) begin
                        r_state <= (r_state == bcir_pkg::S_DDIV) ? bcir_pkg::S_DWR
                                                                 : bcir_pkg::S_RUMUL;
                    end
                end
                bcir_pkg::S_DWR: begin
                    r_ccnt  <= r_ccnt + PW'(1);
                    r_state <= bcir_pkg::S_DNEXT;
                end
                bcir_pkg::S_DNEXT: begin
                    if (r_j + CW'(1) < r_cnt) begin
                        r_j <= r_j + CW'(1);
                        r_state <= bcir_pkg::S_DRD;
                    end else if (r_i + CW'(2) < r_cnt) begin
                        r_i <= r_i + CW'(1);
                        r_j <= r_i + CW'(2);
                        r_state <= bcir_pkg::S_DRD;
                    end else begin
                        r_k <= '0;
                        r_state <= (r_ccnt == '0) ? bcir_pkg::S_ORD : bcir_pkg::S_RRD;
                    end
                end
                bcir_pkg::S_RRD: begin
                    r_state <= bcir_pkg::S_RVRD;
                end
                bcir_pkg::S_RVRD: begin
                    r_state <= bcir_pkg::S_RMUL;
                end
                bcir_pkg::S_RMUL: begin
                    r_px  <= dvx * r_cd.nx;
                    r_py  <= dvy * r_cd.ny;
                    r_tot <= 25'(r_spa.inv_mass) + 25'(r_spb.inv_mass);
                    r_bp  <= 32'(r_spa.bounce) * 32'(r_spb.bounce);
                    r_state <= bcir_pkg::S_RDOT;
                end
                bcir_pkg::S_RDOT: begin
                    r_s <= negdot[49:15];
                    r_e <= r_bp[31:15];
                    // separating pair or two immovable sprites
                    if ((!dot[49] && dot != '0) || r_tot == '0) begin
                        r_state <= bcir_pkg::S_RNEXT;
                    end else begin
                        r_state <= bcir_pkg::S_RSE;
                    end
                end
                bcir_pkg::S_RSE: begin
                    r_se <= 52'(r_s) * 52'(r_e);
                    r_state <= bcir_pkg::S_RDV;
                end
                bcir_pkg::S_RDV: begin
                    r_pa <= 63'(dv) * 63'(r_spa.inv_mass);
                    r_pb <= 63'(dv) * 63'(r_spb.inv_mass);
                    r_state <= bcir_pkg::S_RDVLD;
                end
                bcir_pkg::S_RDVLD: begin
                    // quotient fits 39 bits, so the top of the product is below the divisor
                    r_dr[0] <= RW'(r_pa[62:DW]);
                    r_dr[1] <= RW'(r_pb[62:DW]);
                    r_dd[0] <= r_pa[DW-1:0];
                    r_dd[1] <= r_pb[DW-1:0];
                    r_dq[0] <= '0;
                    r_dq[1] <= '0;
                    r_dsor  <= RW'(r_tot);
                    r_dcnt  <= bcir_pkg::IMP_STEPS;
                    r_state <= bcir_pkg::S_RDIV;
                end
                bcir_pkg::S_RUMUL: begin
                    r_uxa <= r_cd.nx * $signed({1'b0, r_dq[0]});
                    r_uya <= r_cd.ny * $signed({1'b0, r_dq[0]});
                    r_uxb <= r_cd.nx * $signed({1'b0, r_dq[1]});
                    r_uyb <= r_cd.ny * $signed({1'b0, r_dq[1]});
                    r_state <= bcir_pkg::S_RWA;
                end
                bcir_pkg::S_RWA: begin
                    r_state <= bcir_pkg::S_RWB;
                end
                bcir_pkg::S_RWB: begin
                    r_state <= bcir_pkg::S_RNEXT;
                end
                bcir_pkg::S_RNEXT: begin
                    if (k1 < r_ccnt) begin
                        r_k <= k1;
                        r_state <= bcir_pkg::S_RRD;
                    end else begin
                        r_k <= '0;
                        r_state <= bcir_pkg::S_ORD;
                    end
                end
                bcir_pkg::S_ORD: begin
                    r_state <= bcir_pkg::S_OEMIT;
                end
                bcir_pkg::S_OEMIT: begin
                    if (k1 == PW'(r_cnt)) begin
                        r_cnt  <= '0;
                        r_ccnt <= '0;
                        r_state <= bcir_pkg::S_IDLE;
                    end else begin
                        r_k <= k1;
                        r_state <= bcir_pkg::S_ORD;
                    end
                end
                default: begin
                    r_state <= bcir_pkg::S_IDLE;
                end
            endcase
        end
    end

    assign o_valid           = (r_state == bcir_pkg::S_OEMIT);
    assign o_sprite_index    = 6'(r_k);
    assign o_new_vel_x       = r_va.vx;
    assign o_new_vel_y       = r_va.vy;
    assign o_collision_count = 11'(r_ccnt);
    assign o_last_result     = o_valid && (k1 == PW'(r_cnt));

endmodule

@@ rtl/bcir_checker.sv @@
// port-level checks for the box collision impulse resolver, bound to the top level
// depends on box_collision_impulse_resolver_defines.svh
`include "box_collision_impulse_resolver_defines.svh"

module bcir_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic start,
    input logic busy,
    input logic i_last_sprite,
    input logic o_valid,
    input logic o_last_result
);

    // a word goes out only while a set is being worked on
    `BCIR_ASSERT(a_valid_busy, i_clk, i_rst_n, o_valid |-> busy)
    // results never come in back-to-back cycles
    `BCIR_ASSERT(a_valid_gap, i_clk, i_rst_n, o_valid |=> !o_valid)
    // loading a sprite that does not close the set keeps the block free
    `BCIR_ASSERT(a_load_free, i_clk, i_rst_n, start && !busy && !i_last_sprite |=> !busy)
    // the final result ends the set
    `BCIR_ASSERT(a_last_done, i_clk, i_rst_n, o_valid && o_last_result |=> !busy)
    // reset returns to idle
    `BCIR_ASSERT_ALWAYS(a_reset_idle, i_clk, !i_rst_n |=> !busy && !o_valid)

endmodule

bind box_collision_impulse_resolver bcir_checker u_bcir_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .start         (start),
    .busy          (busy),
    .i_last_sprite (i_last_sprite),
    .o_valid       (o_valid),
    .o_last_result (o_last_result)
);
